### design/pcse_pkg.sv
// shared types, constants and helpers for the pixel command stream encoder
package pcse_pkg;

  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned ONE_BYTE_LIMIT = 256;

  typedef logic [COORD_BITS-1:0] coord_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1,
    CFG_PALETTE_MODE  = 2'd2,
    CFG_BUFFERED_DRAW = 2'd3
  } cfg_reg_e;

  localparam coord_t WIDTH_RESET  = coord_t'(320);
  localparam coord_t HEIGHT_RESET = coord_t'(180);

  // command opcodes
  localparam logic [7:0] OP_MOVE  = 8'd5;
  localparam logic [7:0] OP_PIXEL = 8'd6;

  // byte slots of one command, in stream order
  localparam int unsigned NUM_STEPS = 9;
  typedef logic [NUM_STEPS-1:0] step_mask_t;
  typedef logic [3:0]           step_idx_t;

  localparam step_idx_t STEP_MOVE  = 4'd0;
  localparam step_idx_t STEP_X_HI  = 4'd1;
  localparam step_idx_t STEP_X_LO  = 4'd2;
  localparam step_idx_t STEP_Y_HI  = 4'd3;
  localparam step_idx_t STEP_Y_LO  = 4'd4;
  localparam step_idx_t STEP_PIXEL = 4'd5;
  localparam step_idx_t STEP_RED   = 4'd6;
  localparam step_idx_t STEP_GREEN = 4'd7;
  localparam step_idx_t STEP_BLUE  = 4'd8;

  // one classified pixel write waiting to be serialized
  typedef struct packed {
    step_mask_t  steps;
    coord_t      x;
    coord_t      y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } cmd_t;

  function automatic logic [7:0] coord_hi(coord_t v);
    logic [15:0] ext;
    ext = 16'(v);
    return ext[15:8];
  endfunction

  function automatic logic [7:0] coord_lo(coord_t v);
    logic [15:0] ext;
    ext = 16'(v);
    return ext[7:0];
  endfunction

endpackage

### design/pcse_front.sv
// front end: config registers, bounds check, cursor tracking and command classification
module pcse_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  pcse_pkg::cfg_reg_e                cfg_index_i,
  input  logic [pcse_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                              accept_i,
  input  logic [15:0]                       pixel_x_i,
  input  logic [15:0]                       pixel_y_i,
  input  logic [7:0]                        red_or_index_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        blue_i,
  output logic                              push_o,
  output pcse_pkg::cmd_t                    cmd_o
);

  pcse_pkg::coord_t width_q, width_d;
  pcse_pkg::coord_t height_q, height_d;
  logic             palette_q, palette_d;
  logic             buffered_q, buffered_d;
  pcse_pkg::coord_t col_q, col_d;
  pcse_pkg::coord_t row_q, row_d;

  pcse_pkg::coord_t             x, y, base_col, base_row;
  logic                         in_bounds, moved, wide_w, wide_h, draw;
  logic [pcse_pkg::COORD_BITS:0] col_inc, row_inc;
  pcse_pkg::step_mask_t         steps;

  always_comb begin
    x         = pixel_x_i[pcse_pkg::COORD_BITS-1:0];
    y         = pixel_y_i[pcse_pkg::COORD_BITS-1:0];
    in_bounds = (x < width_q) && (y < height_q);
    moved     = (x != col_q) || (y != row_q);
    wide_w    = 32'(width_q) > 32'(pcse_pkg::ONE_BYTE_LIMIT);
    wide_h    = 32'(height_q) > 32'(pcse_pkg::ONE_BYTE_LIMIT);
    draw      = !buffered_q;

    steps = '0;
    steps[pcse_pkg::STEP_MOVE]  = moved;
    steps[pcse_pkg::STEP_X_HI]  = moved && wide_w;
    steps[pcse_pkg::STEP_X_LO]  = moved;
    steps[pcse_pkg::STEP_Y_HI]  = moved && wide_h;
    steps[pcse_pkg::STEP_Y_LO]  = moved;
    steps[pcse_pkg::STEP_PIXEL] = draw;
    steps[pcse_pkg::STEP_RED]   = draw;
    steps[pcse_pkg::STEP_GREEN] = draw && !palette_q;
    steps[pcse_pkg::STEP_BLUE]  = draw && !palette_q;

    cmd_o.steps = steps;
    cmd_o.x     = x;
    cmd_o.y     = y;
    cmd_o.r     = red_or_index_i;
    cmd_o.g     = green_i;
    cmd_o.b     = blue_i;

    push_o = accept_i && in_bounds && (|steps);

    // cursor advance from the written position; the row stays below the height
    base_col = x;
    base_row = y;
    col_inc  = (pcse_pkg::COORD_BITS+1)'(base_col) + 1'b1;
    row_inc  = (pcse_pkg::COORD_BITS+1)'(base_row) + 1'b1;

    width_d    = width_q;
    height_d   = height_q;
    palette_d  = palette_q;
    buffered_d = buffered_q;
    col_d      = col_q;
    row_d      = row_q;

    if (accept_i && in_bounds) begin
      if (col_inc >= {1'b0, width_q}) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, height_q}) ? '0
                                              : row_inc[pcse_pkg::COORD_BITS-1:0];
      end else begin
        col_d = col_inc[pcse_pkg::COORD_BITS-1:0];
        row_d = base_row;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcse_pkg::CFG_CANVAS_WIDTH: begin
          width_d = cfg_wdata_i[pcse_pkg::COORD_BITS-1:0];
          col_d   = '0;
          row_d   = '0;
        end
        pcse_pkg::CFG_CANVAS_HEIGHT: begin
          height_d = cfg_wdata_i[pcse_pkg::COORD_BITS-1:0];
          col_d    = '0;
          row_d    = '0;
        end
        pcse_pkg::CFG_PALETTE_MODE:  palette_d  = cfg_wdata_i[0];
        pcse_pkg::CFG_BUFFERED_DRAW: buffered_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= pcse_pkg::WIDTH_RESET;
      height_q   <= pcse_pkg::HEIGHT_RESET;
      palette_q  <= 1'b0;
      buffered_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      palette_q  <= palette_d;
      buffered_q <= buffered_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

### design/pcse_queue.sv
// two-entry command queue between front and back end
module pcse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcse_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output pcse_pkg::cmd_t head_cmd_o
);

  pcse_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    full_o       = count_q == 2'd2;
    head_valid_o = count_q != 2'd0;
    head_cmd_o   = mem_q[rd_ptr_q];
    wr_ptr_d     = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d     = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d      = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### design/pcse_back.sv
// back end: serializes queued commands into bytes through an output register
module pcse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  pcse_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o
);

  function automatic pcse_pkg::step_idx_t first_step(pcse_pkg::step_mask_t m);
    pcse_pkg::step_idx_t idx;
    idx = '0;
    for (int i = pcse_pkg::NUM_STEPS - 1; i >= 0; i--) begin
      if (m[i]) idx = pcse_pkg::step_idx_t'(i);
    end
    return idx;
  endfunction

  pcse_pkg::step_mask_t done_q, done_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;

  pcse_pkg::step_mask_t rem, one_hot;
  pcse_pkg::step_idx_t  cur;
  logic                 load, is_last;
  logic [7:0]           sel_byte;

  always_comb begin
    rem     = head_cmd_i.steps & ~done_q;
    cur     = first_step(rem);
    is_last = (rem & (rem - pcse_pkg::step_mask_t'(1))) == '0;
    one_hot = pcse_pkg::step_mask_t'(1) << cur;

    case (cur)
      pcse_pkg::STEP_MOVE:  sel_byte = pcse_pkg::OP_MOVE;
      pcse_pkg::STEP_X_HI:  sel_byte = pcse_pkg::coord_hi(head_cmd_i.x);
      pcse_pkg::STEP_X_LO:  sel_byte = pcse_pkg::coord_lo(head_cmd_i.x);
      pcse_pkg::STEP_Y_HI:  sel_byte = pcse_pkg::coord_hi(head_cmd_i.y);
      pcse_pkg::STEP_Y_LO:  sel_byte = pcse_pkg::coord_lo(head_cmd_i.y);
      pcse_pkg::STEP_PIXEL: sel_byte = pcse_pkg::OP_PIXEL;
      pcse_pkg::STEP_RED:   sel_byte = head_cmd_i.r;
      pcse_pkg::STEP_GREEN: sel_byte = head_cmd_i.g;
      pcse_pkg::STEP_BLUE:  sel_byte = head_cmd_i.b;
      default:              sel_byte = '0;
    endcase

    load    = head_valid_i && (!valid_q || out_ready_i);
    pop_o   = load && is_last;

    done_d  = done_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = sel_byte;
      last_d  = is_last;
      done_d  = is_last ? '0 : (done_q | one_hot);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end

    out_valid_o = valid_q;
    out_byte_o  = byte_q;
    last_byte_o = last_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

endmodule

### design/pixel_command_stream_encoder.sv
// top level: pixel writes in, canvas command byte stream out
// with the back end idle, the first byte of a write is registered in the queue and then in the output register
// throughput: one output byte per cycle while writes are queued and out_ready_i is high;
//   a write emits four bytes for an rgb pixel at the cursor and up to nine after a jump
// the back end's byte serializer sets that figure; a two-deep queue decouples the input
// reset: canvas 320 x 180, rgb direct draw, cursor at column 0 row 0, queue and output empty
module pixel_command_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // pixel write channel
  input  logic        pixel_valid_i,
  output logic        pixel_ready_o,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  input  logic [7:0]  red_or_index_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  // command byte channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  logic                accept;
  logic                push;
  logic                pop;
  logic                full;
  logic                head_valid;
  pcse_pkg::cmd_t      push_cmd;
  pcse_pkg::cmd_t      head_cmd;
  pcse_pkg::cfg_reg_e  cfg_index;

  // a write is taken whenever the queue has room, even while output bytes wait
  assign pixel_ready_o = !full;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign cfg_index     = pcse_pkg::cfg_reg_e'(cfg_index_i);

  // front: bounds check, cursor compare and advance, byte slot selection
  pcse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .red_or_index_i (red_or_index_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // only writes that emit at least one byte are queued
  pcse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // back: one byte per transfer, last flag on the final byte of each write
  pcse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### bench/pixel_command_stream_encoder_tb.sv
// self-checking testbench for the pixel command stream encoder
`timescale 1ns / 1ps

module pixel_command_stream_encoder_tb;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned ITEMS_PER_SET = 44;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 10;

  // one pixel write as offered on the input channel
  typedef struct packed {
    pcse_pkg::coord_t x;
    pcse_pkg::coord_t y;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
  } pixel_write_t;

  // one command byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_byte_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = '0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        pixel_valid_i  = 1'b0;
  logic        pixel_ready_o;
  logic [15:0] pixel_x_i      = '0;
  logic [15:0] pixel_y_i      = '0;
  logic [7:0]  red_or_index_i = '0;
  logic [7:0]  green_i        = '0;
  logic [7:0]  blue_i         = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  pixel_command_stream_encoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .red_or_index_i (red_or_index_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  // shadow of the block's registers and cursor, as the predictor sees them
  pcse_pkg::coord_t canvas_w      = pcse_pkg::WIDTH_RESET;
  pcse_pkg::coord_t canvas_h      = pcse_pkg::HEIGHT_RESET;
  bit               palette_mode  = 1'b0;
  bit               buffered_mode = 1'b0;
  pcse_pkg::coord_t cursor_col    = '0;
  pcse_pkg::coord_t cursor_row    = '0;

  // where the stimulus generator believes the cursor is, used to build runs
  pcse_pkg::coord_t plan_col = '0;
  pcse_pkg::coord_t plan_row = '0;

  pixel_write_t pixel_writes_pending[$];
  cmd_byte_t    expected_stream[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one column right; past the last column back to column 0 and one row down,
  // the row wrapping modulo the canvas height
  function automatic void advance_cursor(inout pcse_pkg::coord_t col,
                                         inout pcse_pkg::coord_t row);
    logic [16:0] row_next;
    col = col + 1'b1;
    if (col >= canvas_w) begin
      col      = '0;
      row_next = {1'b0, row} + 17'd1;
      row      = pcse_pkg::coord_t'(row_next % {1'b0, canvas_h});
    end
  endfunction

  // bytes that one accepted pixel write produces, appended to expected_stream
  function automatic void encode_pixel_write(input pixel_write_t pw);
    logic [7:0] seq[$];
    if (pw.x >= canvas_w || pw.y >= canvas_h) return;   // dropped, cursor kept
    if (pw.x != cursor_col || pw.y != cursor_row) begin
      cursor_col = pw.x;
      cursor_row = pw.y;
      seq.push_back(pcse_pkg::OP_MOVE);
      // a coordinate needs its high byte only on a dimension wider than 256
      if (canvas_w > pcse_pkg::ONE_BYTE_LIMIT) seq.push_back(pw.x[15:8]);
      seq.push_back(pw.x[7:0]);
      if (canvas_h > pcse_pkg::ONE_BYTE_LIMIT) seq.push_back(pw.y[15:8]);
      seq.push_back(pw.y[7:0]);
    end
    if (!buffered_mode) begin
      seq.push_back(pcse_pkg::OP_PIXEL);
      seq.push_back(pw.r);
      if (!palette_mode) begin
        seq.push_back(pw.g);
        seq.push_back(pw.b);
      end
    end
    advance_cursor(cursor_col, cursor_row);
    foreach (seq[i]) expected_stream.push_back('{data: seq[i], last: (i == seq.size() - 1)});
  endfunction

  // per-item wait, with occasional switches into a run of back-to-back transfers
  function automatic int unsigned draw_gap(inout bit fast);
    if ($urandom_range(24, 0) == 0) fast = !fast;
    return fast ? 0 : $urandom_range(19, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: presents pending writes with random gaps between them
  // ---------------------------------------------------------------------------
  pixel_write_t offered;
  int unsigned  send_gap;
  int unsigned  next_gap;
  bit           send_fast = 1'b0;

  task automatic present(input pixel_write_t pw);
    pixel_x_i      <= pw.x;
    pixel_y_i      <= pw.y;
    red_or_index_i <= pw.r;
    green_i        <= pw.g;
    blue_i         <= pw.b;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
      send_gap      <= 0;
    end else if (pixel_valid_i && pixel_ready_o) begin
      // transfer: predict now, then either offer the next write at once or idle
      encode_pixel_write(offered);
      next_gap = draw_gap(send_fast);
      if (next_gap == 0 && pixel_writes_pending.size() > 0) begin
        offered = pixel_writes_pending.pop_front();
        present(offered);
        pixel_valid_i <= 1'b1;
      end else begin
        pixel_valid_i <= 1'b0;
        send_gap      <= next_gap;
      end
    end else if (!pixel_valid_i) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pixel_writes_pending.size() > 0) begin
        offered = pixel_writes_pending.pop_front();
        present(offered);
        pixel_valid_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks every byte transfer and throttles ready
  // ---------------------------------------------------------------------------
  cmd_byte_t   wanted;
  int unsigned recv_hold;
  int unsigned hold_draw;
  int unsigned long_holds = 0;
  bit          recv_fast = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_hold   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_stream.size() == 0) begin
        $error("out_byte: no transfer expected, got %0h", out_byte_o);
        mismatches++;
      end else begin
        wanted = expected_stream.pop_front();
        if (out_byte_o !== wanted.data) begin
          $error("out_byte: expected %0h, got %0h", wanted.data, out_byte_o);
          mismatches++;
        end
        if (last_byte_o !== wanted.last) begin
          $error("last_byte: expected %0b, got %0b", wanted.last, last_byte_o);
          mismatches++;
        end
      end
      // back-pressure: a long hold while plenty of writes are still queued,
      // so the block's input queue fills and it drops ready
      if (long_holds < 2 && pixel_writes_pending.size() >= 30) begin
        hold_draw = LONG_HOLD;
        long_holds++;
      end else begin
        hold_draw = draw_gap(recv_fast);
      end
      if (hold_draw == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        recv_hold   <= hold_draw - 1;
      end
    end else if (!out_ready_i) begin
      if (recv_hold == 0) out_ready_i <= 1'b1;
      else recv_hold <= recv_hold - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pixel_command_stream_encoder: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // register write; the shadow follows at the edge that takes it
  task automatic write_reg(input pcse_pkg::cfg_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pcse_pkg::CFG_CANVAS_WIDTH, pcse_pkg::CFG_CANVAS_HEIGHT: begin
        if (idx == pcse_pkg::CFG_CANVAS_WIDTH) canvas_w = value;
        else canvas_h = value;
        // a size write sends the cursor home
        cursor_col = '0;
        cursor_row = '0;
        plan_col   = '0;
        plan_row   = '0;
      end
      pcse_pkg::CFG_PALETTE_MODE:  palette_mode  = value[0];
      pcse_pkg::CFG_BUFFERED_DRAW: buffered_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic set_canvas(input logic [15:0] w, input logic [15:0] h,
                            input bit pal, input bit bufd);
    write_reg(pcse_pkg::CFG_CANVAS_WIDTH, w);
    write_reg(pcse_pkg::CFG_CANVAS_HEIGHT, h);
    write_reg(pcse_pkg::CFG_PALETTE_MODE, {15'd0, pal});
    write_reg(pcse_pkg::CFG_BUFFERED_DRAW, {15'd0, bufd});
  endtask

  // queue one write and keep the plan cursor in step with the block
  task automatic queue_write(input pcse_pkg::coord_t x, input pcse_pkg::coord_t y,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_writes_pending.push_back('{x: x, y: y, r: r, g: g, b: b});
    if (x < canvas_w && y < canvas_h) begin
      plan_col = x;
      plan_row = y;
      advance_cursor(plan_col, plan_row);
    end
  endtask

  // mostly sequential runs from the cursor, some jumps, some writes off the canvas
  task automatic queue_random_writes(input int unsigned count);
    int unsigned      kind;
    pcse_pkg::coord_t x;
    pcse_pkg::coord_t y;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(99, 0);
      if (canvas_w == 0 || canvas_h == 0 || kind >= 85) begin
        if ($urandom_range(1, 0) == 0) begin
          x = pcse_pkg::coord_t'($urandom_range(65535, 0));
          y = pcse_pkg::coord_t'($urandom_range(65535, 0));
        end else begin
          // just past an edge
          x = ($urandom_range(1, 0) == 0) ? canvas_w
                                          : pcse_pkg::coord_t'($urandom_range(65535, 0));
          y = (x >= canvas_w) ? pcse_pkg::coord_t'($urandom_range(65535, 0)) : canvas_h;
        end
      end else if (kind < 70) begin
        x = plan_col;
        y = plan_row;
      end else if (kind < 78) begin
        x = pcse_pkg::coord_t'($urandom_range(canvas_w - 1, 0));
        y = pcse_pkg::coord_t'($urandom_range(canvas_h - 1, 0));
      end else begin
        // jump to an edge, so the run that follows wraps soon
        x = ($urandom_range(1, 0) == 0) ? canvas_w - 1'b1 : '0;
        y = ($urandom_range(1, 0) == 0) ? canvas_h - 1'b1 : '0;
      end
      queue_write(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // wait until every write is taken and every byte has come out, sampled away
  // from the rising edge, then let the block settle
  task automatic drain;
    @(negedge clk_i);
    while (pixel_writes_pending.size() > 0 || pixel_valid_i || expected_stream.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_set(input logic [15:0] w, input logic [15:0] h,
                            input bit pal, input bit bufd);
    set_canvas(w, h, pal, bufd);
    queue_random_writes(ITEMS_PER_SET);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset canvas 320 x 180, rgb, direct draw
    queue_write(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);          // at the cursor, no move
    queue_write(16'd1, 16'd0, 8'hff, 8'hff, 8'hff);          // sequential
    queue_write(16'd319, 16'd0, 8'ha5, 8'h5a, 8'h3c);        // jump, two-byte column
    queue_write(16'd0, 16'd1, 8'h11, 8'h22, 8'h33);          // row wrap
    queue_write(16'd319, 16'd179, 8'h80, 8'h01, 8'hfe);      // bottom right corner
    queue_write(16'd0, 16'd0, 8'h7f, 8'h40, 8'h20);          // row wraps to top
    queue_write(16'd320, 16'd0, 8'hff, 8'h00, 8'hff);        // off the right edge
    queue_write(16'd0, 16'd180, 8'hff, 8'h00, 8'hff);        // off the bottom
    queue_write(16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);    // far off, cursor kept
    queue_write(16'd1, 16'd0, 8'h55, 8'haa, 8'h55);          // still sequential
    queue_write(16'd256, 16'd100, 8'h01, 8'h02, 8'h04);      // jump
    drain();

    // palette index only
    set_canvas(16'd320, 16'd180, 1'b1, 1'b0);
    queue_write(16'd0, 16'd0, 8'hc3, 8'h00, 8'h00);          // home after a size write
    queue_write(16'd5, 16'd5, 8'h3c, 8'hff, 8'hff);
    drain();

    // buffered draw: only moves go out, the cursor still advances
    set_canvas(16'd320, 16'd180, 1'b0, 1'b1);
    queue_write(16'd0, 16'd0, 8'h12, 8'h34, 8'h56);          // no bytes at all
    queue_write(16'd1, 16'd0, 8'h12, 8'h34, 8'h56);          // no bytes at all
    queue_write(16'd10, 16'd10, 8'h12, 8'h34, 8'h56);        // move only
    queue_write(16'd11, 16'd10, 8'h12, 8'h34, 8'h56);
    drain();

    // zero width, then zero height: every write dropped
    set_canvas(16'd0, 16'd180, 1'b0, 1'b0);
    queue_write(16'd0, 16'd0, 8'h01, 8'h01, 8'h01);
    queue_write(16'd0, 16'd1, 8'h01, 8'h01, 8'h01);
    drain();
    set_canvas(16'd320, 16'd0, 1'b0, 1'b0);
    queue_write(16'd0, 16'd0, 8'h01, 8'h01, 8'h01);
    queue_write(16'd5, 16'd0, 8'h01, 8'h01, 8'h01);
    drain();

    // random part over a spread of canvas shapes and modes
    random_set(16'd320, 16'd180, 1'b0, 1'b0);
    random_set(16'd256, 16'd256, 1'b1, 1'b0);                // widest one-byte coordinates
    random_set(16'd257, 16'd257, 1'b0, 1'b0);                // narrowest two-byte coordinates
    random_set(16'd1, 16'd1, 1'b0, 1'b0);
    random_set(16'hffff, 16'hffff, 1'b0, 1'b1);
    random_set(16'hffff, 16'hffff, 1'b1, 1'b0);
    random_set(16'd16, 16'd8, 1'b0, 1'b0);
    random_set(16'd1, 16'd300, 1'b0, 1'b0);
    random_set(16'd300, 16'd1, 1'b1, 1'b1);

    if (mismatches == 0) begin
      $display("pixel_command_stream_encoder: match");
    end else begin
      $display("pixel_command_stream_encoder: mismatch");
    end
    $finish;
  end

endmodule

### pixel_command_stream_encoder.f
design/pcse_pkg.sv
design/pcse_front.sv
design/pcse_queue.sv
design/pcse_back.sv
design/pixel_command_stream_encoder.sv
bench/pixel_command_stream_encoder_tb.sv
